// File: hdl/cfeoa_pkg.sv
// Shared constants, widths and helpers for the ring queue with running mean.
package cfeoa_pkg;

   localparam int SLOTS   = 8;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int KEY_W   = 16;
   localparam int RATE_W  = 8;
   localparam int WORD_W  = KEY_W + RATE_W;
   localparam int HELD_W  = 3;
   localparam int TOTAL_W = $clog2((SLOTS - 1) * 255 + 1);
   localparam int NUM_W   = TOTAL_W + 1;
   localparam int QUOT_W  = RATE_W;
   localparam int STEP_W  = $clog2(QUOT_W);
   localparam int CMP_W   = NUM_W + QUOT_W;

   // operation codes on the cmd field
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // ring pointer advance, wraps at the last cell
   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(SLOTS - 1)) nxt = '0;
      else nxt = idx + IDX_W'(1);
      return nxt;
   endfunction

endpackage

// File: hdl/cfeoa_slot_ram.sv
// Simple dual-port slot memory, registered read.
module cfeoa_slot_ram #(
   parameter int DEPTH  = 8,
   parameter int WIDTH  = 24,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cfeoa_divider.sv
// Restoring divider, one quotient bit per cycle.
module cfeoa_divider
   import cfeoa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [IDX_W-1:0]  denom,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   logic [NUM_W-1:0]  rem_ff,  rem_in;
   logic [IDX_W-1:0]  den_ff,  den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CMP_W-1:0]  shifted;
   logic              fits;

   always_comb begin
      shifted = CMP_W'(den_ff) << step_ff;
      fits    = CMP_W'(rem_ff) >= shifted;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         den_in  = denom;
         quot_in = '0;
         step_in = STEP_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - shifted[NUM_W-1:0];
            quot_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: hdl/circular_fifo_evict_oldest_average.sv
// Ring queue with oldest-entry eviction and rounded running mean of held rates.
// Sequence: the head slot is read at accept; a remove then hands its result to the
//   output register, while an insert first runs the mean divider that retires one
//   quotient bit per cycle and then hands off its rounded mean.
// Flow: one item at a time; a new request waits until the last result is handed off.
// Reset (synchronous): pointers, count, total and handshakes clear; slot cells
//   hold whatever they held and are only read once written.
module circular_fifo_evict_oldest_average
   import cfeoa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [KEY_W-1:0]  req_entry_key,
   input  logic [RATE_W-1:0] req_entry_rate,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [RATE_W-1:0] rsp_mean_rate,
   output logic              rsp_popped_valid,
   output logic [KEY_W-1:0]  rsp_popped_key,
   output logic [RATE_W-1:0] rsp_popped_rate,
   output logic              rsp_empty_error,
   output logic [HELD_W-1:0] rsp_held_count
);

   // sequencer: idle -> slot read returns -> (mean divide) -> result handoff
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   occ_ff, occ_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // result waiting for the output register
   logic [RATE_W-1:0]  pend_mean_ff, pend_mean_in;
   logic               pend_pop_ff, pend_pop_in;
   logic [KEY_W-1:0]   pend_key_ff, pend_key_in;
   logic [RATE_W-1:0]  pend_rate_ff, pend_rate_in;
   logic               pend_err_ff, pend_err_in;
   logic [HELD_W-1:0]  pend_held_ff, pend_held_in;

   // output register, parts the queue from the consumer
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic               rsp_pop_ff, rsp_pop_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [RATE_W-1:0]  rsp_rate_ff, rsp_rate_in;
   logic               rsp_err_ff, rsp_err_in;
   logic [HELD_W-1:0]  rsp_held_ff, rsp_held_in;

   logic               accept;
   logic               full;
   logic               empty;
   logic               ram_wr_en;
   logic [WORD_W-1:0]  ram_rd_data;
   logic [KEY_W-1:0]   head_key;
   logic [RATE_W-1:0]  head_rate;
   logic               div_start;
   logic [NUM_W-1:0]   div_numer;
   logic               div_done;
   logic [QUOT_W-1:0]  div_quot;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (occ_ff == IDX_W'(SLOTS - 1));
   assign empty     = (occ_ff == '0);
   assign head_rate = ram_rd_data[RATE_W-1:0];
   assign head_key  = ram_rd_data[WORD_W-1:RATE_W];
   assign ram_wr_en = (state_ff == S_EXEC) && (cmd_ff == CMD_INSERT);

   // head cell is read at accept; the previous item has written back by then,
   // so the read always sees current contents
   cfeoa_slot_ram #(
      .DEPTH (SLOTS),
      .WIDTH (WORD_W),
      .ADDR_W(IDX_W)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(tail_ff),
      .wr_data({key_ff, rate_ff}),
      .rd_en  (accept),
      .rd_addr(head_ff),
      .rd_data(ram_rd_data)
   );

   cfeoa_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (occ_in),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rate_in      = rate_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      total_in     = total_ff;
      pend_mean_in = pend_mean_ff;
      pend_pop_in  = pend_pop_ff;
      pend_key_in  = pend_key_ff;
      pend_rate_in = pend_rate_ff;
      pend_err_in  = pend_err_ff;
      pend_held_in = pend_held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_pop_in   = rsp_pop_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_held_in  = rsp_held_ff;
      div_start    = 1'b0;
      div_numer    = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               key_in   = req_entry_key;
               rate_in  = req_entry_rate;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            pend_mean_in = '0;
            pend_pop_in  = 1'b0;
            pend_key_in  = '0;
            pend_rate_in = '0;
            pend_err_in  = 1'b0;
            if (cmd_ff == CMD_INSERT) begin
               // full queue: head leaves silently, its rate leaves the total
               if (full) begin
                  head_in  = next_index(head_ff);
                  total_in = total_ff - TOTAL_W'(head_rate) + TOTAL_W'(rate_ff);
               end else begin
                  occ_in   = occ_ff + IDX_W'(1);
                  total_in = total_ff + TOTAL_W'(rate_ff);
               end
               tail_in      = next_index(tail_ff);
               pend_held_in = HELD_W'(occ_in);
               // round half up: (total + count/2) / count
               div_start    = 1'b1;
               div_numer    = NUM_W'(total_in) + NUM_W'(occ_in >> 1);
               state_in     = S_DIV;
            end else if (empty) begin
               pend_err_in  = 1'b1;
               pend_held_in = HELD_W'(occ_ff);
               state_in     = S_DONE;
            end else begin
               pend_pop_in  = 1'b1;
               pend_key_in  = head_key;
               pend_rate_in = head_rate;
               head_in      = next_index(head_ff);
               occ_in       = occ_ff - IDX_W'(1);
               total_in     = total_ff - TOTAL_W'(head_rate);
               pend_held_in = HELD_W'(occ_in);
               state_in     = S_DONE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               pend_mean_in = div_quot;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = pend_mean_ff;
               rsp_pop_in   = pend_pop_ff;
               rsp_key_in   = pend_key_ff;
               rsp_rate_in  = pend_rate_ff;
               rsp_err_in   = pend_err_ff;
               rsp_held_in  = pend_held_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      rate_ff      <= rate_in;
      pend_mean_ff <= pend_mean_in;
      pend_pop_ff  <= pend_pop_in;
      pend_key_ff  <= pend_key_in;
      pend_rate_ff <= pend_rate_in;
      pend_err_ff  <= pend_err_in;
      pend_held_ff <= pend_held_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_pop_ff   <= rsp_pop_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_held_ff  <= rsp_held_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_rate    = rsp_mean_ff;
   assign rsp_popped_valid = rsp_pop_ff;
   assign rsp_popped_key   = rsp_key_ff;
   assign rsp_popped_rate  = rsp_rate_ff;
   assign rsp_empty_error  = rsp_err_ff;
   assign rsp_held_count   = rsp_held_ff;

   // count never reaches the ring size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= IDX_W'(SLOTS - 1))
      else $error("occupancy exceeds capacity");

   // pointer distance tracks the count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      ((int'(tail_ff) - int'(head_ff) + SLOTS) % SLOTS) == int'(occ_ff))
      else $error("head/tail distance disagrees with occupancy");

   // divider only finishes while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   // an accepted transfer enters execution and blocks the input channel
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC) && !req_ready)
      else $error("accepted item did not enter execution");

endmodule
